FILE: rtl/teletext_attribute_decoder_core_assert.svh
// Assertion macros shared by the teletext attribute decoder RTL.
`ifndef TELETEXT_ATTRIBUTE_DECODER_CORE_ASSERT_SVH
`define TELETEXT_ATTRIBUTE_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("teletext attribute decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define TAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("teletext attribute decoder check failed");

`endif

FILE: rtl/tad_pkg.sv
// Types, constants and glyph tables for the teletext attribute decoder.
package tad_pkg;

    localparam logic [15:0] SPACE_CP         = 16'h0020;
    localparam logic [15:0] MOSAIC_BASE      = 16'hE200;
    localparam logic [15:0] DH_UPPER_TEXT    = 16'hE000;
    localparam logic [15:0] DH_LOWER_TEXT    = 16'hE100;
    localparam logic [15:0] SEP_OFFSET       = 16'h00C0;
    localparam logic [15:0] DH_UPPER_MOSAIC  = 16'h0040;
    localparam logic [15:0] DH_LOWER_MOSAIC  = 16'h0080;

    localparam logic [2:0]  COLOUR_BLACK     = 3'd0;
    localparam logic [2:0]  COLOUR_WHITE     = 3'd7;

    localparam logic [6:0]  ROW_LENGTH_RESET = 7'd40;
    localparam logic [6:0]  ROW_LENGTH_MIN   = 7'd1;
    localparam logic [6:0]  ROW_LENGTH_MAX   = 7'd64;

    // Control code groups, selected by bits 4:3 of a control code.
    localparam logic [1:0]  CC_GRP_ALPHA     = 2'b00;
    localparam logic [1:0]  CC_GRP_MOSAIC    = 2'b10;

    localparam logic [4:0]  CC_FLASH         = 5'h08;
    localparam logic [4:0]  CC_STEADY        = 5'h09;
    localparam logic [4:0]  CC_NORMAL_HEIGHT = 5'h0C;
    localparam logic [4:0]  CC_DOUBLE_HEIGHT = 5'h0D;
    localparam logic [4:0]  CC_CONCEAL       = 5'h18;
    localparam logic [4:0]  CC_CONTIGUOUS    = 5'h19;
    localparam logic [4:0]  CC_SEPARATED     = 5'h1A;
    localparam logic [4:0]  CC_BLACK_BG      = 5'h1C;
    localparam logic [4:0]  CC_NEW_BG        = 5'h1D;
    localparam logic [4:0]  CC_HOLD          = 5'h1E;
    localparam logic [4:0]  CC_RELEASE       = 5'h1F;

    typedef struct packed {
        logic [5:0]  column_count;
        logic        graphics_mode;
        logic        separated_style;
        logic [2:0]  next_foreground;
        logic [2:0]  background;
        logic [2:0]  span_foreground;
        logic [2:0]  span_background;
        logic        span_flash;
        logic        span_open;
        logic        double_height;
        logic        lower_half_row;
        logic        next_row_lower;
        logic        flash_flag;
        logic        conceal_flag;
        logic        hold_flag;
        logic [15:0] held_glyph;
        logic        last_mosaic_valid;
        logic [15:0] last_mosaic_glyph;
    } attr_state_t;

    localparam attr_state_t ATTR_STATE_RESET = '{
        column_count:      6'd0,
        graphics_mode:     1'b0,
        separated_style:   1'b0,
        next_foreground:   COLOUR_WHITE,
        background:        COLOUR_BLACK,
        span_foreground:   COLOUR_WHITE,
        span_background:   COLOUR_BLACK,
        span_flash:        1'b0,
        span_open:         1'b0,
        double_height:     1'b0,
        lower_half_row:    1'b0,
        next_row_lower:    1'b0,
        flash_flag:        1'b0,
        conceal_flag:      1'b0,
        hold_flag:         1'b0,
        held_glyph:        SPACE_CP,
        last_mosaic_valid: 1'b0,
        last_mosaic_glyph: SPACE_CP
    };

    // Character set remaps for text glyphs.
    function automatic logic [15:0] text_base(input logic [6:0] c);
        logic [7:0] g;
        begin
            unique case (c)
                7'h23:   g = 8'hA3;
                7'h5C:   g = 8'hBD;
                7'h5F:   g = 8'h23;
                7'h7B:   g = 8'hBC;
                7'h7D:   g = 8'hBE;
                7'h7E:   g = 8'hF7;
                7'h7F:   g = 8'hB6;
                default: g = {1'b0, c};
            endcase
            return {8'h00, g};
        end
    endfunction

endpackage

FILE: rtl/teletext_attribute_decoder_core.sv
// Teletext serial attribute decoder: one screen byte in, one decoded cell out.
//
// Channel  Direction  Handshake              Payload
// s_       in         s_valid / s_ready      s_char_byte
// m_       out        m_valid / m_ready      m_codepoint, colours, flash, span flags, row end
// cfg_     in         cfg_valid / cfg_ready  cfg_row_length
//
// One byte is accepted in every cycle unless the output stalls; its result passes through
// the input register and the result register. The input register feeds the attribute
// logic, which updates the row state and loads the result register. Reset is synchronous
// and restores the start-of-row attributes and a row length of 40. A stalled result
// register holds back the input register, and s_ready falls only when both are full.
module teletext_attribute_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_codepoint,
    output logic [2:0]  m_fg_colour,
    output logic [2:0]  m_bg_colour,
    output logic        m_flash_on,
    output logic        m_close_span,
    output logic        m_open_span,
    output logic        m_end_of_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_row_length
);
    import tad_pkg::*;

    logic        in_valid_reg;
    logic [6:0]  in_byte_reg;
    logic [6:0]  row_length_reg;
    attr_state_t state_reg;
    attr_state_t state_mid;
    attr_state_t state_next;

    logic        m_valid_reg;
    logic [15:0] codepoint_reg;
    logic [2:0]  fg_colour_reg;
    logic [2:0]  bg_colour_reg;
    logic        flash_on_reg;
    logic        close_span_reg;
    logic        open_span_reg;
    logic        end_of_row_reg;

    logic        advance;
    logic [6:0]  c;
    logic        displayable;
    logic        mosaic_cell;
    logic [15:0] glyph;
    logic [15:0] cell_cp;
    logic [2:0]  fore;
    logic        span_change;
    logic        close_s;
    logic        open_s;
    logic [6:0]  len_eff;
    logic [6:0]  col_inc;
    logic        eor;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign c           = in_byte_reg;
    assign displayable = (c[6:5] != 2'b00);
    assign mosaic_cell = state_reg.graphics_mode && c[5];

    always_comb begin
        glyph = SPACE_CP;
        if (c == SPACE_CP[6:0]) begin
            glyph = SPACE_CP;
        end else if (!state_reg.double_height && state_reg.lower_half_row) begin
            glyph = SPACE_CP;
        end else if (mosaic_cell) begin
            glyph = MOSAIC_BASE + {10'd0, c[6], c[4:0]};
            if (state_reg.separated_style) begin
                glyph = glyph + SEP_OFFSET;
            end
            if (state_reg.double_height) begin
                glyph = glyph + (state_reg.lower_half_row ? DH_LOWER_MOSAIC : DH_UPPER_MOSAIC);
            end
        end else begin
            glyph = text_base(c);
            if (state_reg.double_height) begin
                glyph = glyph + (state_reg.lower_half_row ? DH_LOWER_TEXT : DH_UPPER_TEXT);
            end
        end
    end

    always_comb begin
        state_mid = state_reg;
        cell_cp   = SPACE_CP;

        if (displayable) begin
            cell_cp = glyph;
            if (state_reg.hold_flag && mosaic_cell) begin
                state_mid.held_glyph = glyph;
            end
        end else if (c[4:3] == CC_GRP_ALPHA && c[2:0] != 3'd0) begin
            cell_cp                   = state_reg.held_glyph;
            state_mid.graphics_mode   = 1'b0;
            state_mid.next_foreground = c[2:0];
            state_mid.conceal_flag    = 1'b0;
            state_mid.hold_flag       = 1'b0;
            state_mid.held_glyph      = SPACE_CP;
        end else if (c[4:3] == CC_GRP_MOSAIC && c[2:0] != 3'd0) begin
            cell_cp                   = state_reg.held_glyph;
            state_mid.graphics_mode   = 1'b1;
            state_mid.next_foreground = c[2:0];
            state_mid.conceal_flag    = 1'b0;
        end else begin
            unique case (c[4:0])
                CC_FLASH:  state_mid.flash_flag = 1'b1;
                CC_STEADY: state_mid.flash_flag = 1'b0;
                CC_NORMAL_HEIGHT: begin
                    if (state_reg.double_height) begin
                        state_mid.hold_flag  = 1'b0;
                        state_mid.held_glyph = SPACE_CP;
                    end
                    state_mid.double_height = 1'b0;
                end
                CC_DOUBLE_HEIGHT: begin
                    if (!state_reg.double_height) begin
                        state_mid.hold_flag  = 1'b0;
                        state_mid.held_glyph = SPACE_CP;
                    end
                    state_mid.double_height  = 1'b1;
                    state_mid.next_row_lower = !state_reg.lower_half_row;
                end
                CC_CONCEAL:    state_mid.conceal_flag    = 1'b1;
                CC_CONTIGUOUS: state_mid.separated_style = 1'b0;
                CC_SEPARATED:  state_mid.separated_style = 1'b1;
                CC_BLACK_BG:   state_mid.background      = COLOUR_BLACK;
                CC_NEW_BG:     state_mid.background      = state_reg.next_foreground;
                CC_HOLD: begin
                    if (state_reg.last_mosaic_valid) begin
                        state_mid.held_glyph = state_reg.last_mosaic_glyph;
                    end
                    state_mid.hold_flag = 1'b1;
                end
                CC_RELEASE: begin
                    state_mid.hold_flag  = 1'b0;
                    state_mid.held_glyph = SPACE_CP;
                end
                default: ;
            endcase
            cell_cp = state_mid.held_glyph;
        end

        state_mid.last_mosaic_valid = mosaic_cell;
        state_mid.last_mosaic_glyph = mosaic_cell ? cell_cp : SPACE_CP;

        fore = state_reg.next_foreground;
        if (state_mid.background == fore) begin
            cell_cp = SPACE_CP;
            fore    = COLOUR_WHITE;
        end else if (state_mid.conceal_flag) begin
            cell_cp = SPACE_CP;
        end

        close_s     = 1'b0;
        open_s      = 1'b0;
        span_change = (state_mid.background != state_reg.span_background) ||
                      ((cell_cp != SPACE_CP) &&
                       ((fore != state_reg.span_foreground) ||
                        (state_mid.flash_flag != state_reg.span_flash)));
        if (span_change) begin
            if (state_reg.span_open) begin
                close_s             = 1'b1;
                state_mid.span_open = 1'b0;
            end
            if (state_mid.background != COLOUR_BLACK || cell_cp != SPACE_CP) begin
                if (fore != COLOUR_WHITE || state_mid.background != COLOUR_BLACK ||
                    state_mid.flash_flag) begin
                    open_s              = 1'b1;
                    state_mid.span_open = 1'b1;
                end
                state_mid.span_foreground = fore;
                state_mid.span_flash      = state_mid.flash_flag;
            end
            state_mid.span_background = state_mid.background;
        end
    end

    always_comb begin
        if (row_length_reg == 7'd0) begin
            len_eff = ROW_LENGTH_MIN;
        end else if (row_length_reg > ROW_LENGTH_MAX) begin
            len_eff = ROW_LENGTH_MAX;
        end else begin
            len_eff = row_length_reg;
        end
        col_inc = {1'b0, state_reg.column_count} + 7'd1;
        eor     = (col_inc == len_eff);
    end

    always_comb begin
        state_next = state_mid;
        if (eor) begin
            state_next.column_count      = 6'd0;
            state_next.graphics_mode     = 1'b0;
            state_next.next_foreground   = COLOUR_WHITE;
            state_next.background        = COLOUR_BLACK;
            state_next.double_height     = 1'b0;
            state_next.lower_half_row    = state_mid.next_row_lower;
            state_next.next_row_lower    = 1'b0;
            state_next.flash_flag        = 1'b0;
            state_next.separated_style   = 1'b0;
            state_next.hold_flag         = 1'b0;
            state_next.held_glyph        = SPACE_CP;
            state_next.conceal_flag      = 1'b0;
            state_next.last_mosaic_valid = 1'b0;
            state_next.last_mosaic_glyph = SPACE_CP;
        end else begin
            state_next.column_count = col_inc[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            row_length_reg <= ROW_LENGTH_RESET;
            state_reg      <= ATTR_STATE_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                row_length_reg <= cfg_row_length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_char_byte[6:0];
        end
        if (advance) begin
            codepoint_reg  <= cell_cp;
            fg_colour_reg  <= fore;
            bg_colour_reg  <= state_mid.background;
            flash_on_reg   <= state_mid.flash_flag;
            close_span_reg <= close_s;
            open_span_reg  <= open_s;
            end_of_row_reg <= eor;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_codepoint  = codepoint_reg;
    assign m_fg_colour  = fg_colour_reg;
    assign m_bg_colour  = bg_colour_reg;
    assign m_flash_on   = flash_on_reg;
    assign m_close_span = close_span_reg;
    assign m_open_span  = open_span_reg;
    assign m_end_of_row = end_of_row_reg;

`include "teletext_attribute_decoder_core_assert.svh"

    `TAD_ASSERT_NEXT(a_row_end_clears_column, advance && eor, state_reg.column_count == 6'd0)
    `TAD_ASSERT_SAME(a_close_needs_open_span, advance && close_s, state_reg.span_open)
    `TAD_ASSERT_SAME(a_equal_colours_blank,
                     m_valid && (m_fg_colour == m_bg_colour),
                     (m_codepoint == SPACE_CP) && (m_fg_colour == COLOUR_WHITE))

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the teletext attribute decoder core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tad_pkg::*;

    typedef struct packed {
        logic [15:0] codepoint;
        logic [2:0]  fg_colour;
        logic [2:0]  bg_colour;
        logic        flash_on;
        logic        close_span;
        logic        open_span;
        logic        end_of_row;
    } decoded_cell_t;

    typedef struct packed {
        logic [7:0]    char_byte;
        logic          known;
        decoded_cell_t cell_out;
    } directed_row_t;

    localparam decoded_cell_t NO_CELL = '0;

    localparam directed_row_t DIRECTED_ROWS [0:26] = '{
        '{8'h41, 1'b1, '{16'h0041, COLOUR_WHITE, COLOUR_BLACK, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'hC3, 1'b1, '{16'h0043, COLOUR_WHITE, COLOUR_BLACK, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h23, 1'b1, '{16'h00A3, COLOUR_WHITE, COLOUR_BLACK, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h7F, 1'b1, '{16'h00B6, COLOUR_WHITE, COLOUR_BLACK, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h08, 1'b0, NO_CELL},
        '{8'h12, 1'b0, NO_CELL},
        '{8'h7F, 1'b0, NO_CELL},
        '{8'h1A, 1'b0, NO_CELL},
        '{8'h1E, 1'b0, NO_CELL},
        '{8'h0D, 1'b0, NO_CELL},
        '{8'h35, 1'b0, NO_CELL},
        '{8'h1D, 1'b0, NO_CELL},
        '{8'h41, 1'b0, NO_CELL},
        '{8'hDF, 1'b1, '{SPACE_CP, COLOUR_WHITE, COLOUR_BLACK, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'h0D, 1'b0, NO_CELL},
        '{8'h5C, 1'b0, NO_CELL},
        '{8'h17, 1'b0, NO_CELL},
        '{8'hE0, 1'b0, NO_CELL},
        '{8'h18, 1'b0, NO_CELL},
        '{8'h41, 1'b0, NO_CELL},
        '{8'h1C, 1'b0, NO_CELL},
        '{8'h1F, 1'b0, NO_CELL},
        '{8'h09, 1'b0, NO_CELL},
        '{8'h0C, 1'b0, NO_CELL},
        '{8'h19, 1'b0, NO_CELL},
        '{8'h1B, 1'b0, NO_CELL},
        '{8'h80, 1'b0, NO_CELL}
    };

    localparam logic [6:0] PHASE_ROW_LENGTHS [0:8] = '{
        7'd40, 7'd0, 7'd64, 7'd5, 7'd127, 7'd1, 7'd65, 7'd3, 7'd24
    };
    localparam int unsigned PHASE_COUNT    = 10;
    localparam int unsigned HOLD_OFF_CYCLES = 300;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_byte    = 8'h00;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [15:0] m_codepoint;
    logic [2:0]  m_fg_colour;
    logic [2:0]  m_bg_colour;
    logic        m_flash_on;
    logic        m_close_span;
    logic        m_open_span;
    logic        m_end_of_row;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_row_length = 7'd0;

    attr_state_t   row_attrs;
    logic [6:0]    row_length_setting;
    decoded_cell_t expected_cells [$];
    int unsigned   mismatches;
    int unsigned   results_seen;
    bit            quiet_tail;
    int unsigned   hold_off_requests;
    int unsigned   hold_off_served;
    int unsigned   hold_off_left;
    int unsigned   stall_left;

    teletext_attribute_decoder_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_codepoint    (m_codepoint),
        .m_fg_colour    (m_fg_colour),
        .m_bg_colour    (m_bg_colour),
        .m_flash_on     (m_flash_on),
        .m_close_span   (m_close_span),
        .m_open_span    (m_open_span),
        .m_end_of_row   (m_end_of_row),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_row_length (cfg_row_length)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] latin_remap(input logic [6:0] c);
        case (c)
            7'h23:   return 16'h00A3;
            7'h5C:   return 16'h00BD;
            7'h5F:   return 16'h0023;
            7'h7B:   return 16'h00BC;
            7'h7D:   return 16'h00BE;
            7'h7E:   return 16'h00F7;
            7'h7F:   return 16'h00B6;
            default: return {9'd0, c};
        endcase
    endfunction

    function automatic logic [15:0] cell_glyph(input logic [6:0] c, input attr_state_t st);
        logic [15:0] g;
        if (c == 7'h20) return SPACE_CP;
        if (!st.double_height && st.lower_half_row) return SPACE_CP;
        if (st.graphics_mode && c[5]) begin
            g = MOSAIC_BASE + {9'd0, (c < 7'h40) ? c - 7'h20 : c - 7'h40};
            if (st.separated_style) g = g + SEP_OFFSET;
            if (st.double_height) g = g + (st.lower_half_row ? DH_LOWER_MOSAIC : DH_UPPER_MOSAIC);
            return g;
        end
        g = latin_remap(c);
        if (st.double_height) g = g + (st.lower_half_row ? DH_LOWER_TEXT : DH_UPPER_TEXT);
        return g;
    endfunction

    function automatic void drop_hold();
        row_attrs.hold_flag  = 1'b0;
        row_attrs.held_glyph = SPACE_CP;
    endfunction

    // Advances the row attributes by one screen byte and returns the decoded cell.
    task automatic decode_byte(input logic [7:0] screen_byte, output decoded_cell_t res);
        logic [6:0]  c;
        logic [2:0]  fore;
        logic [15:0] cell_cp;
        logic [6:0]  len;
        c       = screen_byte[6:0];
        fore    = row_attrs.next_foreground;
        cell_cp = SPACE_CP;
        res     = '0;

        if (c >= 7'h20) begin
            cell_cp = cell_glyph(c, row_attrs);
            if (row_attrs.hold_flag && row_attrs.graphics_mode && c[5])
                row_attrs.held_glyph = cell_cp;
        end else if (c[4:3] == CC_GRP_ALPHA && c[2:0] != 3'd0) begin
            cell_cp = row_attrs.held_glyph;
            row_attrs.graphics_mode   = 1'b0;
            row_attrs.next_foreground = c[2:0];
            row_attrs.conceal_flag    = 1'b0;
            drop_hold();
        end else if (c[4:3] == CC_GRP_MOSAIC && c[2:0] != 3'd0) begin
            cell_cp = row_attrs.held_glyph;
            row_attrs.graphics_mode   = 1'b1;
            row_attrs.next_foreground = c[2:0];
            row_attrs.conceal_flag    = 1'b0;
        end else begin
            case (c[4:0])
                CC_FLASH:         row_attrs.flash_flag = 1'b1;
                CC_STEADY:        row_attrs.flash_flag = 1'b0;
                CC_NORMAL_HEIGHT: begin
                    if (row_attrs.double_height) drop_hold();
                    row_attrs.double_height = 1'b0;
                end
                CC_DOUBLE_HEIGHT: begin
                    if (!row_attrs.double_height) drop_hold();
                    row_attrs.double_height  = 1'b1;
                    row_attrs.next_row_lower = !row_attrs.lower_half_row;
                end
                CC_CONCEAL:       row_attrs.conceal_flag = 1'b1;
                CC_CONTIGUOUS:    row_attrs.separated_style = 1'b0;
                CC_SEPARATED:     row_attrs.separated_style = 1'b1;
                CC_BLACK_BG:      row_attrs.background = COLOUR_BLACK;
                CC_NEW_BG:        row_attrs.background = fore;
                CC_HOLD: begin
                    if (row_attrs.last_mosaic_valid)
                        row_attrs.held_glyph = row_attrs.last_mosaic_glyph;
                    row_attrs.hold_flag = 1'b1;
                end
                CC_RELEASE:       drop_hold();
                default:          ;
            endcase
            cell_cp = row_attrs.held_glyph;
        end

        if (row_attrs.graphics_mode && c[5]) begin
            row_attrs.last_mosaic_valid = 1'b1;
            row_attrs.last_mosaic_glyph = cell_cp;
        end else begin
            row_attrs.last_mosaic_valid = 1'b0;
            row_attrs.last_mosaic_glyph = SPACE_CP;
        end

        if (row_attrs.background == fore) begin
            cell_cp = SPACE_CP;
            fore    = COLOUR_WHITE;
        end else if (row_attrs.conceal_flag) begin
            cell_cp = SPACE_CP;
        end

        if (row_attrs.background != row_attrs.span_background ||
            (cell_cp != SPACE_CP && (fore != row_attrs.span_foreground ||
                                     row_attrs.flash_flag != row_attrs.span_flash))) begin
            if (row_attrs.span_open) begin
                res.close_span      = 1'b1;
                row_attrs.span_open = 1'b0;
            end
            if (row_attrs.background != COLOUR_BLACK || cell_cp != SPACE_CP) begin
                if (fore != COLOUR_WHITE || row_attrs.background != COLOUR_BLACK ||
                    row_attrs.flash_flag) begin
                    res.open_span       = 1'b1;
                    row_attrs.span_open = 1'b1;
                end
                row_attrs.span_foreground = fore;
                row_attrs.span_flash      = row_attrs.flash_flag;
            end
            row_attrs.span_background = row_attrs.background;
        end

        res.codepoint = cell_cp;
        res.fg_colour = fore;
        res.bg_colour = row_attrs.background;
        res.flash_on  = row_attrs.flash_flag;

        len = row_length_setting;
        if (len == 7'd0) len = ROW_LENGTH_MIN;
        if (len > ROW_LENGTH_MAX) len = ROW_LENGTH_MAX;
        if ({1'b0, row_attrs.column_count} + 7'd1 == len) begin
            res.end_of_row            = 1'b1;
            row_attrs.column_count    = 6'd0;
            row_attrs.graphics_mode   = 1'b0;
            row_attrs.next_foreground = COLOUR_WHITE;
            row_attrs.background      = COLOUR_BLACK;
            row_attrs.double_height   = 1'b0;
            row_attrs.lower_half_row  = row_attrs.next_row_lower;
            row_attrs.next_row_lower  = 1'b0;
            row_attrs.flash_flag      = 1'b0;
            row_attrs.separated_style = 1'b0;
            drop_hold();
            row_attrs.conceal_flag      = 1'b0;
            row_attrs.last_mosaic_valid = 1'b0;
            row_attrs.last_mosaic_glyph = SPACE_CP;
        end else begin
            row_attrs.column_count = row_attrs.column_count + 6'd1;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("%0t ns: result %0d: %s", $time, results_seen, what);
        mismatches++;
    endtask

    function automatic logic [7:0] random_screen_byte();
        logic [6:0]  c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = 7'($urandom_range(32, 127));
        else if (pick < 60)
            c = {2'b00, CC_GRP_MOSAIC, 3'($urandom_range(1, 7))};
        else if (pick < 70)
            c = {2'b00, CC_GRP_ALPHA, 3'($urandom_range(1, 7))};
        else
            c = 7'($urandom_range(0, 31));
        return {1'($urandom_range(0, 1)), c};
    endfunction

    task automatic offer_byte(input logic [7:0] screen_byte, input logic known,
                              input decoded_cell_t known_cell);
        decoded_cell_t predicted;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_byte <= screen_byte;
        do @(posedge aclk); while (!s_ready);
        decode_byte(screen_byte, predicted);
        expected_cells.push_back(known ? known_cell : predicted);
    endtask

    task automatic await_results();
        s_valid <= 1'b0;
        while (expected_cells.size() != 0) @(posedge aclk);
    endtask

    task automatic set_row_length(input logic [6:0] len);
        await_results();
        cfg_valid      <= 1'b1;
        cfg_row_length <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid          <= 1'b0;
        row_length_setting  = len;
    endtask

    always @(posedge aclk) begin
        if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_requests;
            hold_off_left   <= HOLD_OFF_CYCLES;
            m_ready         <= 1'b0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            m_ready       <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        decoded_cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cells.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = expected_cells.pop_front();
                if (m_codepoint !== want.codepoint)
                    report_mismatch($sformatf("codepoint %h, expected %h",
                                              m_codepoint, want.codepoint));
                if (m_fg_colour !== want.fg_colour)
                    report_mismatch($sformatf("fg_colour %0d, expected %0d",
                                              m_fg_colour, want.fg_colour));
                if (m_bg_colour !== want.bg_colour)
                    report_mismatch($sformatf("bg_colour %0d, expected %0d",
                                              m_bg_colour, want.bg_colour));
                if (m_flash_on !== want.flash_on)
                    report_mismatch($sformatf("flash_on %b, expected %b",
                                              m_flash_on, want.flash_on));
                if (m_close_span !== want.close_span)
                    report_mismatch($sformatf("close_span %b, expected %b",
                                              m_close_span, want.close_span));
                if (m_open_span !== want.open_span)
                    report_mismatch($sformatf("open_span %b, expected %b",
                                              m_open_span, want.open_span));
                if (m_end_of_row !== want.end_of_row)
                    report_mismatch($sformatf("end_of_row %b, expected %b",
                                              m_end_of_row, want.end_of_row));
            end
            results_seen++;
        end
    end

    initial begin : stimulus
        int unsigned phase_items;
        logic [6:0]  len;
        row_attrs          = ATTR_STATE_RESET;
        row_length_setting = ROW_LENGTH_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_row_length(7'd12);
        foreach (DIRECTED_ROWS[i])
            offer_byte(DIRECTED_ROWS[i].char_byte, DIRECTED_ROWS[i].known,
                       DIRECTED_ROWS[i].cell_out);

        for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
            len = (phase < PHASE_COUNT - 1) ? PHASE_ROW_LENGTHS[phase]
                                            : 7'($urandom_range(0, 127));
            set_row_length(len);
            quiet_tail  = (phase == PHASE_COUNT - 1);
            phase_items = $urandom_range(130, 170);
            for (int unsigned i = 0; i < phase_items; i++) begin
                if (phase == 2 && i == phase_items / 2)
                    hold_off_requests++;
                if (phase == 6 && i == phase_items / 2)
                    await_results();
                offer_byte(random_screen_byte(), 1'b0, NO_CELL);
            end
        end

        await_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("teletext_attribute_decoder_core: match");
        else
            $display("teletext_attribute_decoder_core: mismatch");
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("teletext_attribute_decoder_core: mismatch");
        $finish;
    end

endmodule
